// ===== sv/lcgt_pkg.sv =====
// ----------------------------------------------------------------------------
// lcgt_pkg
// Shared types and constants of the per-column lidar ground tracker.
// ----------------------------------------------------------------------------
package lcgt_pkg;

    // Field widths fixed by the stream format.
    localparam int COL_W    = 11;
    localparam int COL_SPAN = 1 << COL_W;
    localparam int Z_W      = 16;
    localparam int SH_W     = 14;
    localparam int ROOF_W   = 15;
    localparam int TOL_W    = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 1;

    // Fixed geometry margins in millimetres.
    localparam int ROOF_MARGIN_MM    = 100;
    localparam int ACQUIRE_WINDOW_MM = 250;

    // Result buffer: covers the two pipeline stages plus results waiting downstream.
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    // Reset values of the configuration registers.
    localparam logic [SH_W-1:0]          SENSOR_HEIGHT_RST    = SH_W'(2000);
    localparam logic signed [ROOF_W-1:0] ROOF_HEIGHT_RST      = '0;
    localparam logic [TOL_W-1:0]         GROUND_TOLERANCE_RST = TOL_W'(100);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SENSOR_HEIGHT    = 2'd0,
        REG_ROOF_HEIGHT      = 2'd1,
        REG_GROUND_TOLERANCE = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        MODE_ROOF    = 2'd0,
        MODE_ACQUIRE = 2'd1,
        MODE_TRACK   = 2'd2
    } t_mode;

    typedef struct packed {
        logic [SH_W-1:0]          sensor_height;
        logic signed [ROOF_W-1:0] roof_height;
        logic [TOL_W-1:0]         ground_tolerance;
    } t_cfg;

endpackage

// ===== sv/lidar_column_ground_tracker.sv =====
// ----------------------------------------------------------------------------
// lidar_column_ground_tracker
// Per-column road classifier for a lidar range-image point stream.
// ----------------------------------------------------------------------------
// Points enter on the s stream, one transaction per point; each yields exactly one
// result on the m stream, in order, carrying the echoed column and the road flag.
// A column must see a column-start point before any other point of that column.
// The cfg channel writes sensor height, roof height and ground tolerance; it is
// always ready. The user must write it only while no point is in flight; the
// block does not enforce this. An accepted point passes the index register and
// the state read and update, then waits in the result buffer, offered on the m
// stream, until the receiver is ready to take it.
// Throughput: one point per cycle while s_tready is high, set by the column state
// memory's read-modify-write: one registered read and one write each cycle, with
// the previous point's write forwarded when two neighbouring points share a column.
// Stall: a four-entry result buffer takes up to four points in flight; s_tready
// drops only when four results are pending, so input continues while one waits.
// Reset: configuration returns to its defaults and the pipeline and buffer empty.
// The column state memory is not cleared; column-start points initialize it.
// ----------------------------------------------------------------------------
module lidar_column_ground_tracker
    import lcgt_pkg::*;
#(
    parameter int COLUMN_COUNT = 2048,
    parameter int GAP_LIMIT    = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,   // [10:0] column, [26:11] height_mm
    input  logic [S_TUSER_W-1:0]  i_s_tuser,   // [0] column_start, [1] point_valid
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [M_TDATA_W-1:0]  o_m_tdata,   // [10:0] column_out
    output logic [M_TUSER_W-1:0]  o_m_tuser,   // [0] is_road
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int MEM_DEPTH = (COLUMN_COUNT < COL_SPAN) ? COLUMN_COUNT : COL_SPAN;
    localparam int IDX_W     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int GAP_W     = (GAP_LIMIT > 0) ? $clog2(GAP_LIMIT + 1) : 1;
    localparam int ENTRY_W   = 2 + Z_W + GAP_W;

    t_cfg r_cfg;

    logic                  w_s_accept;
    logic [OUT_CNT_W-1:0]  w_fill;
    logic [OUT_CNT_W-1:0]  w_fifo_count;

    logic                  r_s1_vld;
    logic                  r_s1_start;
    logic                  r_s1_pv;
    logic signed [Z_W-1:0] r_s1_z;
    logic [COL_W-1:0]      w_s1_col;
    logic [IDX_W-1:0]      w_s1_idx;

    logic                  r_s2_vld;
    logic                  r_s2_start;
    logic                  r_s2_pv;
    logic signed [Z_W-1:0] r_s2_z;
    logic [COL_W-1:0]      r_s2_col;
    logic [IDX_W-1:0]      r_s2_idx;

    logic [ENTRY_W-1:0]    w_rd_data;
    logic [ENTRY_W-1:0]    w_cur;
    logic [ENTRY_W-1:0]    w_new;
    logic                  r_fwd_vld;
    logic [IDX_W-1:0]      r_fwd_idx;
    logic [ENTRY_W-1:0]    r_fwd_data;

    t_mode                 w_new_mode;
    logic signed [Z_W-1:0] w_new_last;
    logic [GAP_W-1:0]      w_new_gap;
    logic                  w_road;

    logic                  w_out_valid;
    logic [COL_W-1:0]      w_out_col;
    logic                  w_out_road;

    // Configuration.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sensor_height    <= SENSOR_HEIGHT_RST;
            r_cfg.roof_height      <= ROOF_HEIGHT_RST;
            r_cfg.ground_tolerance <= GROUND_TOLERANCE_RST;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_SENSOR_HEIGHT:    r_cfg.sensor_height    <= i_cfg_data[SH_W-1:0];
                REG_ROOF_HEIGHT:      r_cfg.roof_height      <= i_cfg_data[ROOF_W-1:0];
                REG_GROUND_TOLERANCE: r_cfg.ground_tolerance <= i_cfg_data[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // Admission: every point in the pipeline has a reserved slot in the buffer.
    assign w_fill = OUT_CNT_W'(r_s1_vld) + OUT_CNT_W'(r_s2_vld) + w_fifo_count;
    assign o_s_tready = (w_fill < OUT_CNT_W'(OUT_DEPTH));
    assign w_s_accept = i_s_tvalid && o_s_tready;

    // Stage 1: captured point, tracker index formed from the column.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= w_s_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_accept) begin
            r_s1_start <= i_s_tuser[0];
            r_s1_pv    <= i_s_tuser[1];
            r_s1_z     <= i_s_tdata[COL_W +: Z_W];
        end
    end

    lcgt_col_index #(
        .COLUMN_COUNT (COLUMN_COUNT),
        .IDX_W        (IDX_W)
    ) u_col_index (
        .i_clk  (i_clk),
        .i_load (w_s_accept),
        .i_col  (i_s_tdata[COL_W-1:0]),
        .o_col  (w_s1_col),
        .o_idx  (w_s1_idx)
    );

    // Stage 2: state read returns, update and write back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld  <= 1'b0;
            r_fwd_vld <= 1'b0;
        end else begin
            r_s2_vld  <= r_s1_vld;
            r_fwd_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_start <= r_s1_start;
        r_s2_pv    <= r_s1_pv;
        r_s2_z     <= r_s1_z;
        r_s2_col   <= w_s1_col;
        r_s2_idx   <= w_s1_idx;
        r_fwd_idx  <= r_s2_idx;
        r_fwd_data <= w_new;
    end

    lcgt_state_ram #(
        .DEPTH  (MEM_DEPTH),
        .IDX_W  (IDX_W),
        .DATA_W (ENTRY_W)
    ) u_state_ram (
        .i_clk     (i_clk),
        .i_rd_idx  (w_s1_idx),
        .o_rd_data (w_rd_data),
        .i_wr_en   (r_s2_vld),
        .i_wr_idx  (r_s2_idx),
        .i_wr_data (w_new)
    );

    // The previous point wrote its state at the edge this read was taken.
    assign w_cur = (r_fwd_vld && (r_fwd_idx == r_s2_idx)) ? r_fwd_data : w_rd_data;

    lcgt_classify #(
        .GAP_LIMIT (GAP_LIMIT),
        .GAP_W     (GAP_W)
    ) u_classify (
        .i_cfg         (r_cfg),
        .i_start       (r_s2_start),
        .i_point_valid (r_s2_pv),
        .i_z           (r_s2_z),
        .i_mode        (t_mode'(w_cur[ENTRY_W-1 -: 2])),
        .i_last        (w_cur[GAP_W +: Z_W]),
        .i_gap         (w_cur[GAP_W-1:0]),
        .o_mode        (w_new_mode),
        .o_last        (w_new_last),
        .o_gap         (w_new_gap),
        .o_road        (w_road)
    );

    assign w_new = {w_new_mode, w_new_last, w_new_gap};

    lcgt_out_fifo u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (r_s2_vld),
        .i_col       (r_s2_col),
        .i_road      (w_road),
        .i_pop_ready (i_m_tready),
        .o_valid     (w_out_valid),
        .o_col       (w_out_col),
        .o_road      (w_out_road),
        .o_count     (w_fifo_count)
    );

    assign o_m_tvalid = w_out_valid;
    assign o_m_tdata  = {{(M_TDATA_W-COL_W){1'b0}}, w_out_col};
    assign o_m_tuser  = w_out_road;

endmodule

// ===== sv/lcgt_col_index.sv =====
// ----------------------------------------------------------------------------
// lcgt_col_index
// Input stage register and reduction of the column to a tracker index.
// ----------------------------------------------------------------------------
module lcgt_col_index
    import lcgt_pkg::*;
#(
    parameter int COLUMN_COUNT = 2048,
    parameter int IDX_W        = 11
) (
    input  logic             i_clk,
    input  logic             i_load,
    input  logic [COL_W-1:0] i_col,
    output logic [COL_W-1:0] o_col,
    output logic [IDX_W-1:0] o_idx
);

    logic [COL_W-1:0] r_col;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;

    generate
        if (COLUMN_COUNT >= COL_SPAN) begin : g_direct
            assign o_idx = r_col[IDX_W-1:0];
        end else begin : g_reduce
            // Quotient by a scaled reciprocal; the shift is large enough that the
            // estimate is exact for every column value, so no correction is needed.
            localparam int SHIFT  = COL_W + $clog2(COLUMN_COUNT) + 1;
            localparam int PROD_W = SHIFT + COL_W;
            localparam longint unsigned RECIP =
                ((64'd1 << SHIFT) + COLUMN_COUNT - 1) / COLUMN_COUNT;
            localparam logic [PROD_W-1:0] RECIP_L = PROD_W'(RECIP);
            localparam logic [COL_W-1:0]  COUNT_L = COL_W'(COLUMN_COUNT);

            logic [PROD_W-1:0] w_prod;
            logic [COL_W-1:0]  r_q;
            logic [COL_W-1:0]  w_qc;
            logic [COL_W-1:0]  w_rem;

            assign w_prod = {{(PROD_W-COL_W){1'b0}}, i_col} * RECIP_L;

            always_ff @(posedge i_clk) begin
                if (i_load) begin
                    r_q <= w_prod[PROD_W-1 -: COL_W];
                end
            end

            assign w_qc  = r_q * COUNT_L;
            assign w_rem = r_col - w_qc;
            assign o_idx = w_rem[IDX_W-1:0];
        end
    endgenerate

endmodule

// ===== sv/lcgt_state_ram.sv =====
// ----------------------------------------------------------------------------
// lcgt_state_ram
// Per-column tracker state, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lcgt_state_ram #(
    parameter int DEPTH  = 2048,
    parameter int IDX_W  = 11,
    parameter int DATA_W = 21
) (
    input  logic              i_clk,
    input  logic [IDX_W-1:0]  i_rd_idx,
    output logic [DATA_W-1:0] o_rd_data,
    input  logic              i_wr_en,
    input  logic [IDX_W-1:0]  i_wr_idx,
    input  logic [DATA_W-1:0] i_wr_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_idx];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/lcgt_classify.sv =====
// ----------------------------------------------------------------------------
// lcgt_classify
// Tracker update: classifies one point and forms the new column state.
// ----------------------------------------------------------------------------
module lcgt_classify
    import lcgt_pkg::*;
#(
    parameter int GAP_LIMIT = 4,
    parameter int GAP_W     = 3
) (
    input  t_cfg                    i_cfg,
    input  logic                    i_start,
    input  logic                    i_point_valid,
    input  logic signed [Z_W-1:0]   i_z,
    input  t_mode                   i_mode,
    input  logic signed [Z_W-1:0]   i_last,
    input  logic [GAP_W-1:0]        i_gap,
    output t_mode                   o_mode,
    output logic signed [Z_W-1:0]   o_last,
    output logic [GAP_W-1:0]        o_gap,
    output logic                    o_road
);

    localparam logic [GAP_W:0] GAP_LIMIT_L = (GAP_W+1)'(GAP_LIMIT);

    logic signed [Z_W:0]   w_target;
    logic signed [Z_W:0]   w_z;
    logic signed [Z_W:0]   w_roof_lim;
    logic signed [Z_W:0]   w_acq_d;
    logic signed [Z_W:0]   w_trk_d;
    logic signed [Z_W+1:0] w_trk_d18;
    logic signed [Z_W+1:0] w_tol;
    t_mode                 w_mode;
    logic signed [Z_W-1:0] w_last;
    logic [GAP_W-1:0]      w_gap;
    logic [GAP_W:0]        w_gap_inc;
    logic                  w_trk_ok;
    logic                  w_acq_ok;
    logic                  w_roof_hit;

    assign w_target = -$signed({3'b000, i_cfg.sensor_height});
    assign w_z      = {i_z[Z_W-1], i_z};

    // A column start replaces the stored state before the point is handled.
    always_comb begin
        if (i_start) begin
            w_mode = MODE_ROOF;
            w_last = w_target[Z_W-1:0];
            w_gap  = '0;
        end else begin
            w_mode = i_mode;
            w_last = i_last;
            w_gap  = i_gap;
        end
    end

    assign w_trk_d   = w_z - {w_last[Z_W-1], w_last};
    assign w_trk_d18 = {w_trk_d[Z_W], w_trk_d};
    assign w_tol     = $signed({{(Z_W+2-TOL_W){1'b0}}, i_cfg.ground_tolerance});
    assign w_trk_ok  = i_point_valid &&
                       ((w_trk_d18 >= 0 && w_trk_d18 < w_tol) ||
                        (w_trk_d18 < 0 && (w_trk_d18 + (w_tol <<< 1)) > 0));

    assign w_roof_lim = {{2{i_cfg.roof_height[ROOF_W-1]}}, i_cfg.roof_height}
                        - (Z_W+1)'(ROOF_MARGIN_MM);
    assign w_roof_hit = i_point_valid && (w_z < w_roof_lim);

    assign w_acq_d  = w_z - w_target;
    assign w_acq_ok = i_point_valid &&
                      (w_acq_d < (Z_W+1)'(ACQUIRE_WINDOW_MM)) &&
                      (w_acq_d > -(Z_W+1)'(ACQUIRE_WINDOW_MM));

    assign w_gap_inc = {1'b0, w_gap} + (GAP_W+1)'(1);

    always_comb begin
        o_mode = w_mode;
        o_last = w_last;
        o_gap  = w_gap;
        o_road = 1'b0;
        case (w_mode)
            MODE_TRACK: begin
                if (w_trk_ok) begin
                    o_road = 1'b1;
                    o_last = i_z;
                    o_gap  = '0;
                end else if (w_gap_inc > GAP_LIMIT_L) begin
                    o_mode = MODE_ACQUIRE;
                    o_gap  = '0;
                end else begin
                    o_gap = w_gap_inc[GAP_W-1:0];
                end
            end
            MODE_ACQUIRE: begin
                if (w_acq_ok) begin
                    o_mode = MODE_TRACK;
                    o_last = i_z;
                    o_road = 1'b1;
                end
            end
            default: begin
                // Roof search: a point clearly below the roof moves to acquire and is
                // evaluated as an acquire point in the same step.
                if (w_roof_hit) begin
                    o_mode = MODE_ACQUIRE;
                    if (w_acq_ok) begin
                        o_mode = MODE_TRACK;
                        o_last = i_z;
                        o_road = 1'b1;
                    end
                end
            end
        endcase
    end

endmodule

// ===== sv/lcgt_out_fifo.sv =====
// ----------------------------------------------------------------------------
// lcgt_out_fifo
// Small result buffer that drives the output stream.
// ----------------------------------------------------------------------------
module lcgt_out_fifo
    import lcgt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [COL_W-1:0]     i_col,
    input  logic                 i_road,
    input  logic                 i_pop_ready,
    output logic                 o_valid,
    output logic [COL_W-1:0]     o_col,
    output logic                 o_road,
    output logic [OUT_CNT_W-1:0] o_count
);

    logic [COL_W-1:0]     r_col  [OUT_DEPTH];
    logic                 r_road [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] r_wr_ptr;
    logic [OUT_PTR_W-1:0] r_rd_ptr;
    logic [OUT_CNT_W-1:0] r_count;
    logic                 w_pop;

    assign o_valid = (r_count != '0);
    assign w_pop   = o_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + OUT_PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + OUT_PTR_W'(1);
            end
            if (i_push && !w_pop) begin
                r_count <= r_count + OUT_CNT_W'(1);
            end else if (!i_push && w_pop) begin
                r_count <= r_count - OUT_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_col[r_wr_ptr]  <= i_col;
            r_road[r_wr_ptr] <= i_road;
        end
    end

    assign o_col   = r_col[r_rd_ptr];
    assign o_road  = r_road[r_rd_ptr];
    assign o_count = r_count;

endmodule

// ===== sv/lcgt_checker.sv =====
// ----------------------------------------------------------------------------
// lcgt_checker
// Port-level checks of the ground tracker, bound to the top level.
// ----------------------------------------------------------------------------
module lcgt_checker
    import lcgt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  o_s_tready,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,
    input  logic [S_TUSER_W-1:0]  i_s_tuser,
    input  logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [M_TDATA_W-1:0]  o_m_tdata,
    input  logic [M_TUSER_W-1:0]  o_m_tuser,
    input  logic                  i_cfg_valid,
    input  logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Points accepted whose results have not yet been taken.
    logic [OUT_CNT_W-1:0] r_pending;
    logic                 w_in_tr;
    logic                 w_out_tr;

    assign w_in_tr  = i_s_tvalid && o_s_tready;
    assign w_out_tr = o_m_tvalid && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (w_in_tr && !w_out_tr) begin
            r_pending <= r_pending + OUT_CNT_W'(1);
        end else if (!w_in_tr && w_out_tr) begin
            r_pending <= r_pending - OUT_CNT_W'(1);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) &&
        $stable(o_m_tuser))
        else $error("result changed while the receiver stalled");

    a_ready_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready == (r_pending < OUT_CNT_W'(OUT_DEPTH)))
        else $error("input ready does not follow the free result slots");

    a_no_extra_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (r_pending != '0))
        else $error("result offered without an outstanding point");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && o_s_tready)
        else $error("block not empty after reset");

endmodule

bind lidar_column_ground_tracker lcgt_checker u_lcgt_checker (.*);

// ===== verif/lidar_column_ground_tracker_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_column_ground_tracker_checker
// Watches the point, result and register channels of the ground tracker.
// It keeps its own per-column tracker state, predicts the road label of each
// accepted point and compares every accepted result with the oldest label.
// ----------------------------------------------------------------------------
module lidar_column_ground_tracker_checker
    import lcgt_pkg::*;
#(
    parameter int COLUMN_COUNT = 2048,
    parameter int GAP_LIMIT    = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,   // [10:0] column, [26:11] height_mm
    input  logic [S_TUSER_W-1:0]  i_s_tuser,   // [0] column_start, [1] point_valid
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [M_TDATA_W-1:0]  i_m_tdata,   // [10:0] column_out
    input  logic [M_TUSER_W-1:0]  i_m_tuser,   // [0] is_road
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_points,
    output int                    o_road_points
);

    typedef struct {
        logic [COL_W-1:0] column;
        logic             road;
    } t_label;

    t_label label_q[$];

    t_mode col_mode   [COLUMN_COUNT];
    int    col_ground [COLUMN_COUNT];
    int    col_gaps   [COLUMN_COUNT];

    logic [SH_W-1:0]          cur_sensor_h;
    logic signed [ROOF_W-1:0] cur_roof;
    logic [TOL_W-1:0]         cur_tol;

    int fail_total  = 0;
    int point_total = 0;
    int road_total  = 0;
    int pending_now = 0;

    assign o_fail_count  = fail_total;
    assign o_pending     = pending_now;
    assign o_points      = point_total;
    assign o_road_points = road_total;

    // Advances the tracker of one column by one point and returns its road label.
    function automatic logic classify_point(input logic [COL_W-1:0] col,
                                            input logic start,
                                            input logic signed [Z_W-1:0] z_raw,
                                            input logic valid);
        int    idx;
        int    z;
        int    target;
        int    tol;
        int    roof;
        int    d;
        logic  road;
        logic  accept;
        t_mode m;
        idx    = int'(col) % COLUMN_COUNT;
        z      = z_raw;
        target = -int'(cur_sensor_h);
        tol    = int'(cur_tol);
        roof   = cur_roof;
        road   = 1'b0;
        if (start) begin
            col_mode[idx]   = MODE_ROOF;
            col_ground[idx] = target;
            col_gaps[idx]   = 0;
        end
        m = col_mode[idx];
        if (m == MODE_TRACK) begin
            accept = 1'b0;
            if (valid) begin
                d = z - col_ground[idx];
                accept = (d >= 0 && d < tol) || (d < 0 && d > -2 * tol);
            end
            if (accept) begin
                road            = 1'b1;
                col_ground[idx] = z;
                col_gaps[idx]   = 0;
            end else if (col_gaps[idx] + 1 > GAP_LIMIT) begin
                col_mode[idx] = MODE_ACQUIRE;
                col_gaps[idx] = 0;
            end else begin
                col_gaps[idx] = col_gaps[idx] + 1;
            end
        end else begin
            // Roof search hands over to acquire on the very same point.
            if (m != MODE_ACQUIRE && valid && z < roof - ROOF_MARGIN_MM) begin
                m             = MODE_ACQUIRE;
                col_mode[idx] = MODE_ACQUIRE;
            end
            if (m == MODE_ACQUIRE && valid) begin
                d = z - target;
                if (d < 0) begin
                    d = -d;
                end
                if (d < ACQUIRE_WINDOW_MM) begin
                    col_mode[idx]   = MODE_TRACK;
                    col_ground[idx] = z;
                    road            = 1'b1;
                end
            end
        end
        return road;
    endfunction

    always @(posedge i_clk) begin
        t_label lbl;
        if (!i_rst_n) begin
            cur_sensor_h = SENSOR_HEIGHT_RST;
            cur_roof     = ROOF_HEIGHT_RST;
            cur_tol      = GROUND_TOLERANCE_RST;
            label_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_SENSOR_HEIGHT:    cur_sensor_h = i_cfg_data[SH_W-1:0];
                    REG_ROOF_HEIGHT:      cur_roof     = i_cfg_data[ROOF_W-1:0];
                    REG_GROUND_TOLERANCE: cur_tol      = i_cfg_data[TOL_W-1:0];
                    default: ;
                endcase
            end
            // The new point goes in first, so a same-edge result still pops the oldest.
            if (i_s_tvalid && i_s_tready) begin
                lbl.column = i_s_tdata[COL_W-1:0];
                lbl.road   = classify_point(i_s_tdata[COL_W-1:0], i_s_tuser[0],
                                            i_s_tdata[COL_W+Z_W-1:COL_W], i_s_tuser[1]);
                label_q.push_back(lbl);
                point_total++;
                if (lbl.road) begin
                    road_total++;
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                if (label_q.size() == 0) begin
                    $display("%0t: result with no point pending, got column %0d road %0b",
                             $time, i_m_tdata[COL_W-1:0], i_m_tuser[0]);
                    fail_total++;
                end else begin
                    lbl = label_q.pop_front();
                    if (i_m_tdata[COL_W-1:0] !== lbl.column) begin
                        $display("%0t: column_out expected %0d, got %0d",
                                 $time, lbl.column, i_m_tdata[COL_W-1:0]);
                        fail_total++;
                    end
                    if (i_m_tuser[0] !== lbl.road) begin
                        $display("%0t: is_road of column %0d expected %0b, got %0b",
                                 $time, lbl.column, lbl.road, i_m_tuser[0]);
                        fail_total++;
                    end
                end
            end
        end
        pending_now = label_q.size();
    end

endmodule

// ===== verif/tb_lidar_column_ground_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lidar_column_ground_tracker
// Stimulus and verdict for the per-column lidar ground tracker.
// A directed run walks one column through roof search, acquire, tracking and
// the gap fallback; random points on a few busy columns then follow under
// several register settings, with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_lidar_column_ground_tracker;
    import lcgt_pkg::*;

    localparam int COLUMNS = 2048;
    localparam int GAPS    = 4;
    localparam int HOT_N   = 6;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // [10:0] column, [26:11] height_mm
    logic [S_TUSER_W-1:0]  s_tuser;   // [0] column_start, [1] point_valid
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;   // [10:0] column_out
    logic [M_TUSER_W-1:0]  m_tuser;   // [0] is_road
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int pending;
    int points;
    int road_points;

    bit quiet = 1'b0;
    int settings_used = 1;

    // Stimulus-side view of the registers and of the columns in use.
    int cfg_sh   = 2000;
    int cfg_roof = 0;
    int cfg_tol  = 100;
    bit started [COLUMNS];
    int walk    [COLUMNS];
    int hot     [HOT_N];

    lidar_column_ground_tracker #(
        .COLUMN_COUNT(COLUMNS),
        .GAP_LIMIT   (GAPS)
    ) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    lidar_column_ground_tracker_checker #(
        .COLUMN_COUNT(COLUMNS),
        .GAP_LIMIT   (GAPS)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_points     (points),
        .o_road_points(road_points)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        #3_000_000;
        $display("[lidar_column_ground_tracker] ERROR");
        $finish;
    end

    // Receiver: random stall bursts, always ready once the run goes quiet.
    initial begin
        m_tready = 1'b0;
        forever begin
            if (quiet) begin
                m_tready = 1'b1;
                @(negedge clk);
            end else if ($urandom_range(0, 3) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end else begin
                m_tready = 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
        end
    end

    function automatic int rand_between(input int lo, input int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic int clamp_z(input int v);
        if (v > 32767) begin
            return 32767;
        end
        if (v < -32768) begin
            return -32768;
        end
        return v;
    endfunction

    // Holds one point on the stream until it is accepted; returns at a falling edge.
    task automatic send_point(input int col, input bit start, input int z, input bit valid);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        s_tdata  = {5'b0, 16'(z), 11'(col)};
        s_tuser  = {valid, start};
        s_tvalid = 1'b1;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input int value);
        cfg_index = idx;
        cfg_data  = 16'(value);
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Lets every point drain before the registers change, then picks new busy columns.
    task automatic apply_settings(input int sh, input int roof, input int tol);
        s_tvalid = 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (8) @(negedge clk);
        write_reg(REG_SENSOR_HEIGHT, sh);
        write_reg(REG_ROOF_HEIGHT, roof);
        write_reg(REG_GROUND_TOLERANCE, tol);
        cfg_sh   = sh;
        cfg_roof = roof;
        cfg_tol  = tol;
        settings_used++;
        for (int i = 0; i < HOT_N; i++) begin
            hot[i] = $urandom_range(0, COLUMNS - 1);
        end
    endtask

    // Mostly ground-like walks on a few busy columns, plus obstacles, holes and noise.
    task automatic random_point();
        int col;
        int z;
        int k;
        bit start;
        bit valid;
        if ($urandom_range(0, 99) < 85) begin
            col = hot[$urandom_range(0, HOT_N - 1)];
        end else begin
            col = $urandom_range(0, COLUMNS - 1);
        end
        start = !started[col] || ($urandom_range(0, 99) < 6);
        if (start || $urandom_range(0, 9) == 0) begin
            walk[col] = -cfg_sh + rand_between(-200, 200);
        end
        started[col] = 1'b1;
        valid = 1'b1;
        k = $urandom_range(0, 99);
        if (k < 60) begin
            z = clamp_z(walk[col] + rand_between(-2 * cfg_tol - 20, cfg_tol + 20));
            walk[col] = z;
        end else if (k < 72) begin
            z = clamp_z(cfg_roof + rand_between(-150, 600));
        end else if (k < 80) begin
            z = rand_between(-32768, 32767);
            valid = 1'b0;
        end else if (k < 88) begin
            z = clamp_z(-cfg_sh + rand_between(-300, 300));
        end else begin
            z = rand_between(-32768, 32767);
            valid = $urandom_range(0, 1);
        end
        send_point(col, start, z, valid);
    endtask

    task automatic run_random(input int n);
        repeat (n) random_point();
    endtask

    initial begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_SENSOR_HEIGHT;
        cfg_data  = '0;
        for (int i = 0; i < HOT_N; i++) begin
            hot[i] = $urandom_range(0, COLUMNS - 1);
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed walk under the reset settings: ground at -2000, tolerance 100.
        send_point(0, 1, -2000, 1);     // roof search passes and acquires at once
        send_point(0, 0, -1950, 1);     // small rise is road
        send_point(0, 0, -1850, 1);     // rise equal to the tolerance is a gap
        send_point(0, 0, -2149, 1);     // fall just inside twice the tolerance
        send_point(0, 0, -2349, 1);     // fall of exactly twice the tolerance
        send_point(0, 0, 1000, 0);
        send_point(0, 0, -2349, 0);
        send_point(0, 0, -2149, 0);
        send_point(0, 0, 0, 0);         // fifth gap drops back to acquire
        send_point(0, 0, -1750, 1);     // acquire window edge is exclusive
        send_point(0, 0, -2249, 1);     // re-acquired just inside the window
        send_point(0, 0, -2249, 1);     // zero change while tracking
        send_point(2047, 1, 32767, 1);  // far above the roof
        send_point(2047, 0, -32768, 0);
        send_point(2047, 0, -100, 1);   // exactly at the roof margin, still searching
        send_point(2047, 0, -101, 1);   // below the margin but far from ground
        send_point(2047, 0, -1751, 1);
        send_point(2047, 0, -32768, 1); // huge fall is a gap
        send_point(5, 1, 0, 0);
        send_point(5, 1, -32768, 1);    // start again: clears the column first
        send_point(5, 0, -2000, 1);
        send_point(0, 1, -2000, 1);     // start in the middle of tracking
        started[0]    = 1'b1;
        started[5]    = 1'b1;
        started[2047] = 1'b1;

        apply_settings(1700, 300, 150);
        run_random(90);
        apply_settings(0, 10000, 0);
        run_random(80);
        apply_settings(10000, -10000, 2000);
        run_random(90);
        apply_settings(800, -1000, 40);
        run_random(90);
        quiet = 1'b1;
        apply_settings(2000, 0, 100);
        run_random(100);
        s_tvalid = 1'b0;

        for (int n = 0; n < 2000 && pending != 0; n++) begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);

        $display("Checked %0d points, %0d of them road, across %0d register settings.",
                 points, road_points, settings_used);
        $display("Settings spanned zero and 10000 mm sensor height, +-10000 mm roof, ",
                 "and tolerances from 0 to 2000 mm.");
        if (fail_count == 0 && pending == 0) begin
            $display("[lidar_column_ground_tracker] OK");
        end else begin
            $display("[lidar_column_ground_tracker] ERROR");
        end
        $finish;
    end

endmodule
